@@ rtl/pts_pkg.sv @@
`timescale 1ns / 1ps
package pts_pkg;
   localparam logic [1:0] ACT_OBSERVE  = 2'd0;
   localparam logic [1:0] ACT_SNAPSHOT = 2'd1;
   localparam logic [1:0] ACT_CLEAR    = 2'd2;
   localparam int unsigned NUM_STATS = 15;

   typedef struct packed {
      logic [1:0]  action;
      logic        ok;
      logic [62:0] lat;
      logic [62:0] exe;
      logic [62:0] over;
      logic [63:0] missed;
   } cmd_type;
endpackage

@@ rtl/pts_front.sv @@
`timescale 1ns / 1ps
module pts_front
   import pts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic               req_wait_error,
   input  logic signed [63:0] req_period_ns,
   input  logic signed [63:0] req_scheduled_ns,
   input  logic signed [63:0] req_wake_ns,
   input  logic signed [63:0] req_completion_ns,
   input  logic signed [63:0] req_reported_lateness_ns,
   input  logic [63:0]        req_missed_count_in,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output cmd_type            cmd
);
   // Stage 1: differences. Stage 2: checks.
   logic               s1_valid_ff, s1_valid_in;
   logic [1:0]         s1_action_ff;
   logic               s1_err_ff;
   logic [64:0]        s1_lat_ff, s1_exe_ff, s1_dl_ff;
   logic signed [63:0] s1_done_ff, s1_late_ff, s1_period_ff;
   logic [63:0]        s1_missed_ff;
   logic               s2_valid_ff, s2_valid_in;
   cmd_type            s2_cmd_ff, s2_cmd_in;
   logic               s2_take;
   logic [64:0]        over_w;
   logic signed [64:0] dl_s;

   assign s2_take   = !s2_valid_ff || cmd_ready;
   assign req_ready = !s1_valid_ff || s2_take;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_take ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (req_ready && req_valid) begin
         s1_action_ff <= req_action;
         s1_err_ff    <= req_wait_error || (req_period_ns <= 64'sd0);
         s1_lat_ff    <= 65'($signed({req_wake_ns[63], req_wake_ns})
                         - $signed({req_scheduled_ns[63], req_scheduled_ns}));
         s1_exe_ff    <= 65'($signed({req_completion_ns[63], req_completion_ns})
                         - $signed({req_wake_ns[63], req_wake_ns}));
         s1_dl_ff     <= 65'($signed({req_scheduled_ns[63], req_scheduled_ns})
                         + $signed({req_period_ns[63], req_period_ns}));
         s1_done_ff   <= req_completion_ns;
         s1_late_ff   <= req_reported_lateness_ns;
         s1_period_ff <= req_period_ns;
         s1_missed_ff <= req_missed_count_in;
      end
      if (s2_take) s2_cmd_ff <= s2_cmd_in;
   end

   assign dl_s   = $signed(s1_dl_ff);
   assign over_w = 65'($signed({s1_done_ff[63], s1_done_ff}) - dl_s);

   always_comb begin
      logic ok;
      ok = !s1_err_ff;
      // difference must be non-negative and fit 63 bits
      if (s1_lat_ff[64] || s1_lat_ff[63]) ok = 1'b0;
      if ({s1_late_ff[63], s1_late_ff} != s1_lat_ff) ok = 1'b0;
      if (s1_exe_ff[64] || s1_exe_ff[63]) ok = 1'b0;
      if (s1_dl_ff[64] != s1_dl_ff[63]) ok = 1'b0;
      if (!over_w[64] && over_w[63]) ok = 1'b0;
      s2_cmd_in.action = s1_action_ff;
      s2_cmd_in.ok     = ok && (s1_period_ff != 64'sd0);
      s2_cmd_in.lat    = s1_lat_ff[62:0];
      s2_cmd_in.exe    = s1_exe_ff[62:0];
      s2_cmd_in.over   = over_w[64] ? 63'd0 : over_w[62:0];
      s2_cmd_in.missed = s1_missed_ff;
   end

   assign cmd_valid = s2_valid_ff;
   assign cmd       = s2_cmd_ff;
endmodule

@@ rtl/pts_back.sv @@
`timescale 1ns / 1ps
module pts_back
   import pts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic [3:0]  rsp_stat_index,
   output logic [63:0] rsp_stat_value,
   output logic        rsp_last
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]  state_ff;
   logic [63:0] cyc_ff, lsum_ff, esum_ff, jcnt_ff, jsum_ff, ovc_ff, miss_ff;
   logic [62:0] lmin_ff, lmax_ff, emin_ff, emax_ff, jmin_ff, jmax_ff;
   logic [62:0] prior_ff, ovpk_ff;
   logic        sat_ff;
   logic [3:0]  idx_ff;
   // shared restoring divider, one quotient bit per cycle
   logic [63:0] dq_ff, dd_ff;
   logic [64:0] dr_ff;
   logic [6:0]  dcnt_ff;
   logic [1:0]  dsel_ff;
   logic [62:0] mean_ff [3];
   logic        ov_valid_ff;
   logic        ov_acc_ff, ov_last_ff;
   logic [3:0]  ov_idx_ff;
   logic [63:0] ov_val_ff;
   logic        ov_free;
   logic [64:0] dr_sh, dr_sub;
   logic [63:0] cur_val;

   assign ov_free   = !ov_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == ST_IDLE) && ov_free;
   assign dr_sh  = {dr_ff[63:0], dq_ff[63]};
   assign dr_sub = dr_sh - {1'b0, dd_ff};

   always_comb begin
      case (idx_ff)
         4'd0:  cur_val = cyc_ff;
         4'd1:  cur_val = (cyc_ff != 0) ? {1'b0, lmin_ff} : 64'd0;
         4'd2:  cur_val = (cyc_ff != 0) ? {1'b0, lmax_ff} : 64'd0;
         4'd3:  cur_val = {1'b0, mean_ff[0]};
         4'd4:  cur_val = (cyc_ff != 0) ? {1'b0, emin_ff} : 64'd0;
         4'd5:  cur_val = (cyc_ff != 0) ? {1'b0, emax_ff} : 64'd0;
         4'd6:  cur_val = {1'b0, mean_ff[1]};
         4'd7:  cur_val = jcnt_ff;
         4'd8:  cur_val = (jcnt_ff != 0) ? {1'b0, jmin_ff} : 64'd0;
         4'd9:  cur_val = (jcnt_ff != 0) ? {1'b0, jmax_ff} : 64'd0;
         4'd10: cur_val = {1'b0, mean_ff[2]};
         4'd11: cur_val = ovc_ff;
         4'd12: cur_val = {1'b0, ovpk_ff};
         4'd13: cur_val = miss_ff;
         4'd14: cur_val = {63'd0, sat_ff};
         default: cur_val = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      logic [64:0] t;
      logic [62:0] jit;
      logic        s;
      logic        ov_next;
      // drop the output word once it is taken
      ov_next = ov_valid_ff && !rsp_ready;
      if (reset) begin
         state_ff <= ST_IDLE; ov_valid_ff <= 1'b0;
         cyc_ff <= '0; lsum_ff <= '0; esum_ff <= '0; jcnt_ff <= '0;
         jsum_ff <= '0; ovc_ff <= '0; miss_ff <= '0; lmin_ff <= '0;
         lmax_ff <= '0; emin_ff <= '0; emax_ff <= '0; jmin_ff <= '0;
         jmax_ff <= '0; prior_ff <= '0; ovpk_ff <= '0; sat_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: if (cmd_valid && ov_free) begin
               ov_idx_ff <= 4'd0; ov_val_ff <= 64'd0;
               case (cmd.action)
                  ACT_OBSERVE: begin
                     ov_next = 1'b1; ov_acc_ff <= cmd.ok; ov_last_ff <= 1'b1;
                     if (cmd.ok) begin
                        s = sat_ff;
                        jit = (cmd.lat >= prior_ff) ? cmd.lat - prior_ff
                                                    : prior_ff - cmd.lat;
                        if (cyc_ff == 0) begin
                           lmin_ff <= cmd.lat; lmax_ff <= cmd.lat;
                           emin_ff <= cmd.exe; emax_ff <= cmd.exe;
                        end else begin
                           if (cmd.lat < lmin_ff) lmin_ff <= cmd.lat;
                           if (cmd.lat > lmax_ff) lmax_ff <= cmd.lat;
                           if (cmd.exe < emin_ff) emin_ff <= cmd.exe;
                           if (cmd.exe > emax_ff) emax_ff <= cmd.exe;
                           if (jcnt_ff == 0) begin
                              jmin_ff <= jit; jmax_ff <= jit;
                           end else begin
                              if (jit < jmin_ff) jmin_ff <= jit;
                              if (jit > jmax_ff) jmax_ff <= jit;
                           end
                           t = {1'b0, jsum_ff} + {2'b0, jit};
                           if (t[64]) s = 1'b1;
                           jsum_ff <= t[64] ? '1 : t[63:0];
                           if (&jcnt_ff) s = 1'b1; else jcnt_ff <= jcnt_ff + 64'd1;
                        end
                        t = {1'b0, lsum_ff} + {2'b0, cmd.lat};
                        if (t[64]) s = 1'b1;
                        lsum_ff <= t[64] ? '1 : t[63:0];
                        t = {1'b0, esum_ff} + {2'b0, cmd.exe};
                        if (t[64]) s = 1'b1;
                        esum_ff <= t[64] ? '1 : t[63:0];
                        if (cmd.over != 0) begin
                           if (&ovc_ff) s = 1'b1; else ovc_ff <= ovc_ff + 64'd1;
                           if (cmd.over > ovpk_ff) ovpk_ff <= cmd.over;
                        end
                        t = {1'b0, miss_ff} + {1'b0, cmd.missed};
                        if (t[64]) s = 1'b1;
                        miss_ff <= t[64] ? '1 : t[63:0];
                        if (&cyc_ff) s = 1'b1; else cyc_ff <= cyc_ff + 64'd1;
                        prior_ff <= cmd.lat;
                        sat_ff <= s;
                     end
                  end
                  ACT_SNAPSHOT: begin
                     state_ff <= ST_DIV; dsel_ff <= 2'd0; dcnt_ff <= 7'd0;
                     dq_ff <= lsum_ff; dd_ff <= cyc_ff; dr_ff <= '0;
                  end
                  ACT_CLEAR: begin
                     ov_next = 1'b1; ov_acc_ff <= 1'b1; ov_last_ff <= 1'b1;
                     cyc_ff <= '0; lsum_ff <= '0; esum_ff <= '0; jcnt_ff <= '0;
                     jsum_ff <= '0; ovc_ff <= '0; miss_ff <= '0; lmin_ff <= '0;
                     lmax_ff <= '0; emin_ff <= '0; emax_ff <= '0; jmin_ff <= '0;
                     jmax_ff <= '0; prior_ff <= '0; ovpk_ff <= '0; sat_ff <= 1'b0;
                  end
                  default: begin
                     ov_next = 1'b1; ov_acc_ff <= 1'b0; ov_last_ff <= 1'b1;
                  end
               endcase
            end
            ST_DIV: begin
               if (dcnt_ff == 7'd64) begin
                  // zero divisor yields zero mean
                  mean_ff[dsel_ff] <= (dd_ff == 0) ? 63'd0 : dq_ff[62:0];
                  dcnt_ff <= 7'd0; dr_ff <= '0;
                  if (dsel_ff == 2'd0) begin
                     dsel_ff <= 2'd1; dq_ff <= esum_ff; dd_ff <= cyc_ff;
                  end else if (dsel_ff == 2'd1) begin
                     dsel_ff <= 2'd2; dq_ff <= jsum_ff; dd_ff <= jcnt_ff;
                  end else begin
                     state_ff <= ST_EMIT; idx_ff <= 4'd0;
                  end
               end else begin
                  dcnt_ff <= dcnt_ff + 7'd1;
                  if (!dr_sub[64]) begin
                     dr_ff <= dr_sub; dq_ff <= {dq_ff[62:0], 1'b1};
                  end else begin
                     dr_ff <= dr_sh; dq_ff <= {dq_ff[62:0], 1'b0};
                  end
               end
            end
            ST_EMIT: if (ov_free) begin
               ov_next = 1'b1; ov_acc_ff <= 1'b1;
               ov_idx_ff <= idx_ff; ov_val_ff <= cur_val;
               ov_last_ff <= (idx_ff == 4'(NUM_STATS - 1));
               if (idx_ff == 4'(NUM_STATS - 1)) state_ff <= ST_IDLE;
               else idx_ff <= idx_ff + 4'd1;
            end
            default: state_ff <= ST_IDLE;
         endcase
         ov_valid_ff <= ov_next;
      end
   end

   assign rsp_valid      = ov_valid_ff;
   assign rsp_accepted   = ov_acc_ff;
   assign rsp_stat_index = ov_idx_ff;
   assign rsp_stat_value = ov_val_ff;
   assign rsp_last       = ov_last_ff;
endmodule

@@ rtl/periodic_timing_statistics_unit.sv @@
`timescale 1ns / 1ps
// Observe and clear answer after passing the two front stages and the
// update in the back end. A snapshot runs three 64-step divisions in a
// shared restoring divider and then emits 15 words. Throughput: one observe
// or clear per cycle while no snapshot runs and the result side keeps up.
// Reset: synchronous, active high; clears all statistics and pipeline state.
module periodic_timing_statistics_unit
   import pts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic               req_wait_error,
   input  logic signed [63:0] req_period_ns,
   input  logic signed [63:0] req_scheduled_ns,
   input  logic signed [63:0] req_wake_ns,
   input  logic signed [63:0] req_completion_ns,
   input  logic signed [63:0] req_reported_lateness_ns,
   input  logic [63:0]        req_missed_count_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted,
   output logic [3:0]         rsp_stat_index,
   output logic [63:0]        rsp_stat_value,
   output logic               rsp_last
);
   logic    cmd_valid, cmd_ready;
   cmd_type cmd;

   pts_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_action, .req_wait_error,
      .req_period_ns, .req_scheduled_ns, .req_wake_ns, .req_completion_ns,
      .req_reported_lateness_ns, .req_missed_count_in,
      .cmd_valid, .cmd_ready, .cmd
   );

   pts_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .rsp_valid, .rsp_ready, .rsp_accepted, .rsp_stat_index,
      .rsp_stat_value, .rsp_last
   );
endmodule

@@ rtl/pts_checker.sv @@
`timescale 1ns / 1ps
module pts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_accepted,
   input logic [3:0]  rsp_stat_index,
   input logic [63:0] rsp_stat_value,
   input logic        rsp_last
);
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_stat_index <= 4'd14) else $error("index range");
   a_last14: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stat_index == 4'd14 |-> rsp_last) else $error("last");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last ##1 rsp_valid |->
      rsp_stat_index == $past(rsp_stat_index) + 4'd1) else $error("order");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stat_value)
      && $stable(rsp_accepted) && $stable(rsp_stat_index) && $stable(rsp_last))
      else $error("hold");
endmodule

bind periodic_timing_statistics_unit pts_checker u_pts_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_accepted, .rsp_stat_index,
   .rsp_stat_value, .rsp_last
);
